/* hdl/tams_pkg.sv */
// ----------------------------------------------------------------------------
// tams_pkg: shared types and constants of the tiered actuator move sequencer
// Command classes, move phases, register indexes and reset values.
// ----------------------------------------------------------------------------
package tams_pkg;

  // Fixed field widths
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned MAX_TIER_W  = 4;
  localparam int unsigned TICKS_W     = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Default parameter values
  localparam int unsigned TIER_BITS_DEF  = 4;
  localparam int unsigned COUNT_BITS_DEF = 20;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // Configuration reset values
  localparam logic [MAX_TIER_W-1:0] MAX_TIER_RST   = '0;
  localparam logic [TICKS_W-1:0]    DROP_TICKS_RST = 16'd18750;
  localparam logic [TICKS_W-1:0]    TIER_TICKS_RST = 16'd50000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TIER   = 2'd0,
    REG_DROP_TICKS = 2'd1,
    REG_TIER_TICKS = 2'd2
  } reg_idx_e;

  // Command classes as seen by the back end
  typedef enum logic [2:0] {
    CMD_TICK = 3'd0,
    CMD_DROP = 3'd1,
    CMD_LIFT = 3'd2,
    CMD_MOVE = 3'd3,
    CMD_STOP = 3'd4,
    CMD_BAD  = 3'd5
  } cmd_e;

  // Move phases
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_SINGLE  = 2'd1,
    PH_PRELIFT = 2'd2,
    PH_TIER    = 2'd3
  } phase_e;

  // Classify a raw command code
  function automatic cmd_e decode_cmd(input logic [CMD_W-1:0] code);
    cmd_e kind;
    unique case (code)
      3'd0:    kind = CMD_TICK;
      3'd1:    kind = CMD_DROP;
      3'd2:    kind = CMD_LIFT;
      3'd3:    kind = CMD_MOVE;
      3'd4:    kind = CMD_STOP;
      default: kind = CMD_BAD;
    endcase
    return kind;
  endfunction

endpackage

/* hdl/tams_front.sv */
// ----------------------------------------------------------------------------
// tams_front: command intake
// Accepts input items, classifies the command code and holds the classified
// item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module tams_front #(
  parameter int unsigned TIER_BITS = tams_pkg::TIER_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tams_pkg::CMD_W-1:0]   command_i,
  input  logic [TIER_BITS-1:0]         target_tier_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output tams_pkg::cmd_e               push_kind_o,
  output logic [TIER_BITS-1:0]         push_target_o
);
  import tams_pkg::*;

  logic                 vld_q;
  cmd_e                 kind_q;
  logic [TIER_BITS-1:0] tgt_q;

  // Take a new item when the stage is empty or drains this cycle
  assign in_ready_o = !vld_q || push_ready_i;

  // Hold valid until the queue takes the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Capture the classified item
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= decode_cmd(command_i);
      tgt_q  <= target_tier_i;
    end
  end

  assign push_valid_o  = vld_q;
  assign push_kind_o   = kind_q;
  assign push_target_o = tgt_q;

endmodule

/* hdl/tams_queue.sv */
// ----------------------------------------------------------------------------
// tams_queue: short item queue
// First-in first-out buffer between the intake and the move engine.
// ----------------------------------------------------------------------------
module tams_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = tams_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* hdl/tams_back.sv */
// ----------------------------------------------------------------------------
// tams_back: move engine
// Applies one queued command per cycle to the actuator state unless out_ready_i
// stalls, holds the configuration registers and registers each result item.
// ----------------------------------------------------------------------------
module tams_back #(
  parameter int unsigned TIER_BITS  = tams_pkg::TIER_BITS_DEF,
  parameter int unsigned COUNT_BITS = tams_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tams_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tams_pkg::TICKS_W-1:0]    cfg_data_i,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  tams_pkg::cmd_e                  item_kind_i,
  input  logic [TIER_BITS-1:0]            item_target_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            motor_on_o,
  output logic                            extending_o,
  output logic                            busy_res_o,
  output logic [TIER_BITS-1:0]            current_tier_o,
  output logic                            is_dropped_o,
  output logic                            rejected_o
);
  import tams_pkg::*;

  localparam int unsigned PW    = TICKS_W + TIER_BITS;
  localparam int unsigned WideW = (PW > COUNT_BITS) ? PW : COUNT_BITS;
  localparam int unsigned ExtW  = (TIER_BITS > MAX_TIER_W) ? TIER_BITS : MAX_TIER_W;

  // Configuration registers
  logic [MAX_TIER_W-1:0] max_tier_q;
  logic [TICKS_W-1:0]    drop_ticks_q, tier_ticks_q;

  // Actuator state
  phase_e                phase_q, phase_d;
  logic [TIER_BITS-1:0]  tier_q, tier_d;
  logic [TIER_BITS-1:0]  pend_q, pend_d;
  logic                  dropped_q, dropped_d;
  logic                  drv_on_q, drv_on_d;
  logic                  drv_up_q, drv_up_d;
  logic [COUNT_BITS-1:0] ticks_q, ticks_d;
  logic                  rej;

  // Result register
  logic                 out_vld_q;
  logic                 res_on_q, res_up_q, res_busy_q, res_drop_q, res_rej_q;
  logic [TIER_BITS-1:0] res_tier_q;

  // Tier travel setup (one shared multiplier)
  logic [TIER_BITS-1:0]  trav_tgt, trav_diff;
  logic                  trav_up;
  logic [PW-1:0]         trav_prod;
  logic [WideW-1:0]      trav_wide;
  logic [COUNT_BITS-1:0] trav_ticks;
  logic [ExtW-1:0]       max_ext, tgt_ext;
  logic                  busy, step;

  assign item_ready_o = !out_vld_q || out_ready_i;
  assign step         = item_valid_i && item_ready_o;
  assign busy         = (phase_q != PH_IDLE);

  assign trav_tgt   = (item_kind_i == CMD_MOVE) ? item_target_i : pend_q;
  assign trav_up    = (trav_tgt >= tier_q);
  assign trav_diff  = trav_up ? (trav_tgt - tier_q) : (tier_q - trav_tgt);
  assign trav_prod  = PW'(tier_ticks_q) * PW'(trav_diff);
  assign trav_wide  = WideW'(trav_prod);
  assign trav_ticks = (trav_wide > WideW'({COUNT_BITS{1'b1}})) ?
                      {COUNT_BITS{1'b1}} : COUNT_BITS'(trav_wide);

  assign max_ext = ExtW'(max_tier_q) & ExtW'({TIER_BITS{1'b1}});
  assign tgt_ext = ExtW'(item_target_i);

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tier_q   <= MAX_TIER_RST;
      drop_ticks_q <= DROP_TICKS_RST;
      tier_ticks_q <= TIER_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_TIER:   max_tier_q   <= cfg_data_i[MAX_TIER_W-1:0];
        REG_DROP_TICKS: drop_ticks_q <= cfg_data_i;
        REG_TIER_TICKS: tier_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Update actuator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tier_q    <= '0;
      pend_q    <= '0;
      dropped_q <= 1'b1;
      drv_on_q  <= 1'b0;
      drv_up_q  <= 1'b0;
      ticks_q   <= '0;
    end else if (step) begin
      phase_q   <= phase_d;
      tier_q    <= tier_d;
      pend_q    <= pend_d;
      dropped_q <= dropped_d;
      drv_on_q  <= drv_on_d;
      drv_up_q  <= drv_up_d;
      ticks_q   <= ticks_d;
    end
  end

  // Next phase and drive for the item at the queue head
  always_comb begin
    phase_d   = phase_q;
    tier_d    = tier_q;
    pend_d    = pend_q;
    dropped_d = dropped_q;
    drv_on_d  = drv_on_q;
    drv_up_d  = drv_up_q;
    ticks_d   = ticks_q;
    rej       = 1'b0;
    unique case (item_kind_i)
      CMD_TICK: begin
        if (busy) begin
          if (ticks_q <= COUNT_BITS'(1)) begin
            unique case (phase_q)
              PH_SINGLE: begin
                dropped_d = !drv_up_q;
                phase_d   = PH_IDLE;
                drv_on_d  = 1'b0;
                drv_up_d  = 1'b0;
                ticks_d   = '0;
              end
              PH_PRELIFT: begin
                dropped_d = 1'b0;
                phase_d   = PH_TIER;
                drv_on_d  = 1'b1;
                drv_up_d  = trav_up;
                ticks_d   = trav_ticks;
              end
              default: begin
                tier_d   = pend_q;
                phase_d  = PH_IDLE;
                drv_on_d = 1'b0;
                drv_up_d = 1'b0;
                ticks_d  = '0;
              end
            endcase
          end else begin
            ticks_d = ticks_q - COUNT_BITS'(1);
          end
        end
      end
      CMD_STOP: begin
        phase_d  = PH_IDLE;
        drv_on_d = 1'b0;
        drv_up_d = 1'b0;
        ticks_d  = '0;
      end
      CMD_DROP: begin
        if (busy || dropped_q) begin
          rej = 1'b1;
        end else begin
          phase_d  = PH_SINGLE;
          drv_on_d = 1'b1;
          drv_up_d = 1'b0;
          ticks_d  = COUNT_BITS'(drop_ticks_q);
        end
      end
      CMD_LIFT: begin
        if (busy || !dropped_q) begin
          rej = 1'b1;
        end else begin
          phase_d  = PH_SINGLE;
          drv_on_d = 1'b1;
          drv_up_d = 1'b1;
          ticks_d  = COUNT_BITS'(drop_ticks_q);
        end
      end
      CMD_MOVE: begin
        if (busy || (item_target_i == tier_q) || (tgt_ext > max_ext)) begin
          rej = 1'b1;
        end else begin
          pend_d   = item_target_i;
          drv_on_d = 1'b1;
          if (dropped_q) begin
            phase_d  = PH_PRELIFT;
            drv_up_d = 1'b1;
            ticks_d  = COUNT_BITS'(drop_ticks_q);
          end else begin
            phase_d  = PH_TIER;
            drv_up_d = trav_up;
            ticks_d  = trav_ticks;
          end
        end
      end
      default: begin
        rej = 1'b1;
      end
    endcase
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (item_ready_o) begin
      out_vld_q <= item_valid_i;
    end
  end

  // Capture result fields from the post-step state
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_on_q   <= drv_on_d;
      res_up_q   <= drv_up_d;
      res_busy_q <= (phase_d != PH_IDLE);
      res_tier_q <= tier_d;
      res_drop_q <= dropped_d;
      res_rej_q  <= rej;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign motor_on_o     = res_on_q;
  assign extending_o    = res_up_q;
  assign busy_res_o     = res_busy_q;
  assign current_tier_o = res_tier_q;
  assign is_dropped_o   = res_drop_q;
  assign rejected_o     = res_rej_q;

endmodule

/* hdl/tiered_actuator_move_sequencer.sv */
// Path: an accepted input item is held in the intake register, then in a queue entry,
// and its result is then held in the result register until it is taken.
// Throughput: one item per cycle unless out_ready_i stalls; the move engine applies
// one command per cycle and the single shared tier-travel multiplier sits in that cycle.
// Reset: asynchronous, active low; idle, tier 0, dropped, drive off, default
// configuration (max tier 0, drop 18750 ticks, 50000 ticks per tier).
// ----------------------------------------------------------------------------
// tiered_actuator_move_sequencer: top level
// Intake stage, short queue and move engine for a tiered linear actuator.
// ----------------------------------------------------------------------------
module tiered_actuator_move_sequencer #(
  parameter int unsigned TIER_BITS  = tams_pkg::TIER_BITS_DEF,
  parameter int unsigned COUNT_BITS = tams_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tams_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tams_pkg::TICKS_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tams_pkg::CMD_W-1:0]     command_i,
  input  logic [TIER_BITS-1:0]           target_tier_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           motor_on_o,
  output logic                           extending_o,
  output logic                           busy_res_o,
  output logic [TIER_BITS-1:0]           current_tier_o,
  output logic                           is_dropped_o,
  output logic                           rejected_o
);
  import tams_pkg::*;

  localparam int unsigned QW = $bits(cmd_e) + TIER_BITS;

  logic                 push_valid, push_ready;
  cmd_e                 push_kind;
  logic [TIER_BITS-1:0] push_target;
  logic                 head_valid, head_ready;
  logic [QW-1:0]        head_data;

  tams_front #(
    .TIER_BITS (TIER_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .target_tier_i (target_tier_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_kind_o   (push_kind),
    .push_target_o (push_target)
  );

  tams_queue #(
    .Width (QW),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  ({push_kind, push_target}),
    .rd_valid_o (head_valid),
    .rd_ready_i (head_ready),
    .rd_data_o  (head_data)
  );

  tams_back #(
    .TIER_BITS  (TIER_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .item_valid_i   (head_valid),
    .item_ready_o   (head_ready),
    .item_kind_i    (cmd_e'(head_data[QW-1:TIER_BITS])),
    .item_target_i  (head_data[TIER_BITS-1:0]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .motor_on_o     (motor_on_o),
    .extending_o    (extending_o),
    .busy_res_o     (busy_res_o),
    .current_tier_o (current_tier_o),
    .is_dropped_o   (is_dropped_o),
    .rejected_o     (rejected_o)
  );

endmodule
